// File: rtl/isort_pkg.sv
// shared types and constants for the insertion sorter
`timescale 1ns / 1ps
`default_nettype none
package isort_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CAPACITY_DEF = 16;

  typedef logic signed [DATA_W-1:0] data_t;

  // what a cell hands to the cell above it
  typedef struct packed {
    data_t data;
    logic  gt;
  } isort_link_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic shift;
  } isort_cmd_t;

  // result flags from the controller
  typedef struct packed {
    logic strobe;
    logic final_res;
    logic dropped;
  } isort_res_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } isort_state_e;

endpackage
`default_nettype wire

// File: rtl/isort_cell.sv
// one cell of the insertion chain: one stored value and its compare
`timescale 1ns / 1ps
`default_nettype none
module isort_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 5
) (
  input  wire logic                clk_i,
  input  wire isort_pkg::isort_cmd_t  cmd_i,
  input  wire isort_pkg::data_t       value_i,
  input  wire logic [CntW-1:0]        fill_i,
  input  wire isort_pkg::isort_link_t prev_i,
  input  wire isort_pkg::data_t       next_data_i,
  output isort_pkg::isort_link_t      link_o
);
  import isort_pkg::*;

  data_t data_q, data_d;
  logic  gt;

  // an empty cell counts as holding +infinity
  assign gt = (fill_i <= CntW'(Idx)) || (data_q > value_i);

  always_comb begin
    data_d = data_q;
    if (cmd_i.shift) begin
      data_d = next_data_i;
    end else if (cmd_i.ins && gt) begin
      data_d = prev_i.gt ? prev_i.data : value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign link_o.data = data_q;
  assign link_o.gt   = gt;

endmodule
`default_nettype wire

// File: rtl/isort_ctrl.sv
// load/unload sequencer, fill count and overflow tracking
`timescale 1ns / 1ps
`default_nettype none
module isort_ctrl #(
  parameter int unsigned Capacity = isort_pkg::CAPACITY_DEF,
  parameter int unsigned CntW     = 5
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire logic               last_i,
  output logic                    busy,
  output isort_pkg::isort_cmd_t   cmd_o,
  output logic [CntW-1:0]         fill_o,
  output isort_pkg::isort_res_t   res_o
);
  import isort_pkg::*;

  isort_state_e state_q, state_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic ovf_q, ovf_d;
  logic drop_q, drop_d;
  isort_res_t res_q, res_d;
  logic accept, full;

  assign full   = (fill_q == CntW'(Capacity));
  assign accept = start && (state_q == ST_LOAD);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: if (accept && last_i) state_d = ST_EMIT;
      ST_EMIT: if (fill_q == CntW'(1)) state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    cmd_o.ins   = 1'b0;
    cmd_o.shift = 1'b0;
    unique case (state_q)
      ST_LOAD: cmd_o.ins = accept && !full;
      ST_EMIT: begin
        busy        = 1'b1;
        cmd_o.shift = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_comb begin
    fill_d = fill_q;
    ovf_d  = ovf_q;
    drop_d = drop_q;
    if (cmd_o.shift) begin
      fill_d = fill_q - CntW'(1);
    end else if (accept) begin
      if (!full) fill_d = fill_q + CntW'(1);
      if (last_i) begin
        drop_d = ovf_q || full;
        ovf_d  = 1'b0;
      end else begin
        ovf_d = ovf_q || full;
      end
    end
    res_d.strobe    = cmd_o.shift;
    res_d.final_res = cmd_o.shift && (fill_q == CntW'(1));
    res_d.dropped   = drop_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      drop_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      drop_q  <= drop_d;
      res_q   <= res_d;
    end
  end

  assign fill_o = fill_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

// File: rtl/insertion_sorter.sv
// top level of the stable insertion sorter
`timescale 1ns / 1ps
`default_nettype none
// Stable insertion sorter for signed 32-bit values. Items arrive on value_i
// with last_i marking the final element of a set; an item is taken on a
// clock edge where start is high and busy is low. While a set is loading,
// one item is taken every cycle: each value is broadcast to a chain of
// CAPACITY cells, every cell compares it with its own entry in the same
// cycle and cells holding a strictly greater value move up one place, so
// equal values keep their arrival order. Items beyond CAPACITY are
// discarded. The item flagged last closes the set: from the next cycle busy
// is high and the chain shifts down one cell per cycle, so a set of n held
// values comes out as n results on consecutive cycles, smallest first,
// each shown for one cycle with strobe_o high. The receiver cannot stall
// these results. final_res_o marks the last one of the set and dropped_o is
// high on every result of a set that lost items to overflow. busy falls in
// the cycle the last result appears, so the next set may begin loading
// right away.
module insertion_sorter #(
  parameter int unsigned CAPACITY = isort_pkg::CAPACITY_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire isort_pkg::data_t value_i,
  input  wire logic             last_i,
  output logic                  strobe_o,
  output isort_pkg::data_t      sorted_value_o,
  output logic                  final_res_o,
  output logic                  dropped_o
);
  import isort_pkg::*;

  // fill count must reach CAPACITY itself
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  isort_cmd_t      cmd;
  isort_res_t      res;
  logic [CntW-1:0] fill;
  isort_link_t     links [CAPACITY];
  data_t           out_q;

  isort_ctrl #(
    .Capacity(CAPACITY),
    .CntW    (CntW)
  ) u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .last_i(last_i),
    .busy  (busy),
    .cmd_o (cmd),
    .fill_o(fill),
    .res_o (res)
  );

  // the chain: cell 0 holds the smallest value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    isort_link_t prev;
    data_t       next_data;

    if (i == 0) begin : g_bottom
      // nothing below cell 0 is ever greater than the new value
      assign prev.data = '0;
      assign prev.gt   = 1'b0;
    end else begin : g_mid
      assign prev = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign next_data = '0;
    end else begin : g_below_top
      assign next_data = links[i+1].data;
    end

    isort_cell #(
      .Idx (i),
      .CntW(CntW)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .value_i    (value_i),
      .fill_i     (fill),
      .prev_i     (prev),
      .next_data_i(next_data),
      .link_o     (links[i])
    );
  end

  // result data is captured from the bottom cell as the chain shifts
  always_ff @(posedge clk_i) begin
    if (cmd.shift) begin
      out_q <= links[0].data;
    end
  end

  assign strobe_o       = res.strobe;
  assign final_res_o    = res.final_res;
  assign dropped_o      = res.dropped;
  assign sorted_value_o = out_q;

endmodule
`default_nettype wire

// File: bench/isort_check.sv
// checker for the insertion sorter: predicts each set's sorted output and compares
`timescale 1ns / 1ps
module isort_check #(
  parameter int unsigned CAPACITY = isort_pkg::CAPACITY_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire logic             busy,
  input  wire isort_pkg::data_t value_i,
  input  wire logic             last_i,
  input  wire logic             strobe_o,
  input  wire isort_pkg::data_t sorted_value_o,
  input  wire logic             final_res_o,
  input  wire logic             dropped_o,
  output int                    fail_count,
  output int                    due_count,
  output int                    results_seen,
  output int                    overflow_sets
);
  import isort_pkg::*;

  typedef struct packed {
    data_t value;
    logic  final_res;
    logic  dropped;
  } sorted_res_t;

  data_t       held [CAPACITY];
  int unsigned held_count;
  logic        overflow_seen;
  sorted_res_t sorted_due [$];
  int          fails;
  int          checked;
  int          lossy_sets;

  // stable insert: only strictly greater entries move up
  function automatic void insert_value(input data_t v);
    int unsigned pos;
    pos = held_count;
    while (pos > 0 && held[pos-1] > v) begin
      held[pos] = held[pos-1];
      pos--;
    end
    held[pos] = v;
    held_count++;
  endfunction

  function automatic void close_set();
    sorted_res_t r;
    for (int unsigned k = 0; k < held_count; k++) begin
      r.value     = held[k];
      r.final_res = (k + 1 == held_count);
      r.dropped   = overflow_seen;
      sorted_due.push_back(r);
    end
    if (overflow_seen) lossy_sets++;
    held_count    = 0;
    overflow_seen = 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sorted_res_t want;
    if (!rst_ni) begin
      held_count    = 0;
      overflow_seen = 1'b0;
      sorted_due.delete();
      fails         = 0;
      checked       = 0;
      lossy_sets    = 0;
    end else begin
      // results first: they always belong to sets already closed
      if (strobe_o) begin
        checked++;
        if (sorted_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result with nothing due: value %0d final %0b dropped %0b",
                     $realtime, sorted_value_o, final_res_o, dropped_o);
        end else begin
          want = sorted_due.pop_front();
          if (sorted_value_o !== want.value || final_res_o !== want.final_res ||
              dropped_o !== want.dropped) begin
            fails++;
            if (fails <= 10)
              $display("%0t: wrong result (value/final/dropped): got %0d/%0b/%0b",
                       $realtime, sorted_value_o, final_res_o, dropped_o,
                       ", want %0d/%0b/%0b",
                       want.value, want.final_res, want.dropped);
          end
        end
      end
      if (start && !busy) begin
        if (held_count < CAPACITY) insert_value(value_i);
        else overflow_seen = 1'b1;
        if (last_i) close_set();
      end
    end
    fail_count    <= fails;
    due_count     <= sorted_due.size();
    results_seen  <= checked;
    overflow_sets <= lossy_sets;
  end

endmodule

// File: bench/insertion_sorter_test.sv
// testbench top for the insertion sorter: stimulus, checker hookup and verdict
`timescale 1ns / 1ps
module insertion_sorter_test;
  import isort_pkg::*;

  localparam int unsigned CAPACITY     = isort_pkg::CAPACITY_DEF;
  localparam int          TOTAL_ITEMS  = 160;
  localparam int          MAX_GAP      = 17;
  // slowest run: ~185 items each with the longest gap, plus the emit cycles
  localparam int          CYCLE_LIMIT  = 100000;
  localparam data_t       MAX_VAL      = 32'sh7fffffff;
  localparam data_t       MIN_VAL      = 32'sh80000000;

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  logic  busy;
  data_t value_i;
  logic  last_i;
  logic  strobe_o;
  data_t sorted_value_o;
  logic  final_res_o;
  logic  dropped_o;

  int fail_count;
  int due_count;
  int results_seen;
  int overflow_sets;
  int items_sent;
  int sets_sent;
  int cycles;
  logic burst_mode;

  insertion_sorter #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .value_i       (value_i),
    .last_i        (last_i),
    .strobe_o      (strobe_o),
    .sorted_value_o(sorted_value_o),
    .final_res_o   (final_res_o),
    .dropped_o     (dropped_o)
  );

  isort_check #(
    .CAPACITY(CAPACITY)
  ) u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .value_i       (value_i),
    .last_i        (last_i),
    .strobe_o      (strobe_o),
    .sorted_value_o(sorted_value_o),
    .final_res_o   (final_res_o),
    .dropped_o     (dropped_o),
    .fail_count    (fail_count),
    .due_count     (due_count),
    .results_seen  (results_seen),
    .overflow_sets (overflow_sets)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake or missing results end here
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, due_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // idle cycles before the next item; burst sets never idle
  function automatic int draw_gap();
    if (burst_mode) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // mix of extremes, a tight band that makes ties, and full-range values
  function automatic data_t draw_value();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return MIN_VAL;
    if (pick == 1) return MAX_VAL;
    if (pick <= 4) return data_t'($urandom_range(0, 8)) - data_t'(4);
    return data_t'($urandom);
  endfunction

  // hold start until the item is taken; start stays high across back-to-back items
  task automatic send_item(input data_t v, input logic lst);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    value_i <= v;
    last_i  <= lst;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    if (lst) sets_sent++;
  endtask

  initial begin
    int unsigned set_len;
    int unsigned shape;
    start      <= 1'b0;
    value_i    <= '0;
    last_i     <= 1'b0;
    rst_ni     <= 1'b0;
    items_sent = 0;
    sets_sent  = 0;
    burst_mode = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-item sets at both extremes
    send_item(MAX_VAL, 1'b1);
    send_item(MIN_VAL, 1'b1);

    // small set with both extremes and a tie, randomly paced
    burst_mode = 1'b0;
    send_item(MAX_VAL, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(MIN_VAL, 1'b0);
    send_item(32'sd0, 1'b0);
    send_item(-32'sd1, 1'b1);

    // store fills exactly, then the closing item itself is dropped
    burst_mode = 1'b1;
    for (int i = 0; i <= CAPACITY; i++)
      send_item((i % 2) ? MIN_VAL + data_t'(i) : MAX_VAL - data_t'(i), i == CAPACITY);

    // random sets: mostly within capacity, some exactly full, some overflowing
    while (items_sent < TOTAL_ITEMS) begin
      shape = $urandom_range(0, 9);
      if (shape <= 6) set_len = $urandom_range(1, CAPACITY);
      else if (shape == 7) set_len = CAPACITY;
      else set_len = $urandom_range(CAPACITY + 1, CAPACITY + 8);
      burst_mode = ($urandom_range(0, 2) == 0);
      for (int unsigned i = 0; i < set_len; i++)
        send_item(draw_value(), i + 1 == set_len);
    end
    start <= 1'b0;

    // drain the last set, then allow a full emit pass for anything stray
    while (due_count != 0) @(posedge clk_i);
    repeat (2 * CAPACITY + 4) @(posedge clk_i);

    $display("sent %0d items in %0d sets (%0d sets overflowed), checked %0d sorted results",
             items_sent, sets_sent, overflow_sets, results_seen);
    if (fail_count == 0 && due_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, due_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
